/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/stpb_pkg.sv */
// Shared constants for the seamless tile pixel blend.
// No dependencies.
package stpb_pkg;

    localparam int DIM_BITS     = 13;
    localparam int CH_BITS      = 16;
    localparam int W_BITS       = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 64;
    localparam int CH_VEC_W   = 8 * CH_BITS;

    // divider shapes: distance, weight, colour
    localparam int NDIV_DEN_W = DIM_BITS;
    localparam int NDIV_Q_W   = W_BITS;
    localparam int WDIV_DEN_W = 2 * W_BITS + 2;
    localparam int WDIV_Q_W   = W_BITS + 1;
    localparam int CDIV_DEN_W = 2 * W_BITS;
    localparam int CDIV_Q_W   = CH_BITS;

    localparam logic [W_BITS:0]         W_ONE       = 17'h10000;
    localparam logic [W_BITS:0]         AMBIG_LIMIT = 17'd65530;
    localparam logic [DIM_BITS-1:0]     HALF_RESET  = 13'd512;

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT = 2'd1;

endpackage

/* hdl/stpb_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; quotient must fit Q_W bits (high numerator part below divisor).
module stpb_div #(
    parameter int DEN_W = 13,
    parameter int Q_W   = 16,
    parameter int PAY_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DEN_W+Q_W-1:0]   in_num,
    input  logic [DEN_W-1:0]       in_den,
    input  logic [PAY_W-1:0]       in_pay,
    output logic                   out_valid,
    output logic [Q_W-1:0]         out_quo,
    output logic [PAY_W-1:0]       out_pay
);

    logic [DEN_W-1:0] rem_reg   [0:Q_W];
    logic [Q_W-1:0]   low_reg   [0:Q_W];
    logic [Q_W-1:0]   quo_reg   [0:Q_W];
    logic [DEN_W-1:0] den_reg   [0:Q_W];
    logic [PAY_W-1:0] pay_reg   [0:Q_W];
    logic             valid_reg [0:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= in_num[DEN_W+Q_W-1:Q_W];
            low_reg[0] <= in_num[Q_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= in_den;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W:0] trial;
        logic           take;

        assign trial = {rem_reg[k], low_reg[k][Q_W-1]};
        assign take  = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? DEN_W'(trial - {1'b0, den_reg[k]})
                                     : trial[DEN_W-1:0];
                low_reg[k+1] <= {low_reg[k][Q_W-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][Q_W-2:0], take};
                den_reg[k+1] <= den_reg[k];
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_quo   = quo_reg[Q_W];
    assign out_pay   = pay_reg[Q_W];

endmodule

/* hdl/seamless_tile_pixel_blend.sv */
// One item per cycle sustained while the output register is not held; one result item per input item.
// Three pipelined dividers (distance, weight, colour) set the depth, one bit per stage.
// The whole pipeline advances together; it holds when the output register is full and
// not taken. rst_n clears all valid bits and sets both half sizes to 512.
// Depends on stpb_pkg and stpb_div.
module seamless_tile_pixel_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stpb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [stpb_pkg::DIM_BITS-1:0]       cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x[12:0] pos_y[25:13] orig_red, orig_green, orig_blue, orig_alpha,
    // wrap_red, wrap_green, wrap_blue, wrap_alpha (16 each from bit 26), zero pad
    input  logic [stpb_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_red[15:0] out_green[31:16] out_blue[47:32] out_alpha[63:48]
    output logic [stpb_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import stpb_pkg::*;

    logic [DIM_BITS-1:0] half_width_reg, half_height_reg;
    logic                en;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= HALF_RESET;
            half_height_reg <= HALF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH:  half_width_reg  <= cfg_data;
                REG_HALF_HEIGHT: half_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- distances ----
    logic [DIM_BITS-1:0] pos_x, pos_y, dx, dy;
    logic                sat_x, sat_y;
    logic [NDIV_DEN_W+NDIV_Q_W-1:0] num_x, num_y;
    logic [CH_VEC_W-1:0] ch_in;

    assign pos_x = s_tdata[12:0];
    assign pos_y = s_tdata[25:13];
    assign ch_in = s_tdata[26 +: CH_VEC_W];

    always_comb
    begin
        dx    = (pos_x >= half_width_reg)  ? pos_x - half_width_reg  : half_width_reg - pos_x;
        dy    = (pos_y >= half_height_reg) ? pos_y - half_height_reg : half_height_reg - pos_y;
        sat_x = (dx >= half_width_reg);
        sat_y = (dy >= half_height_reg);
        num_x = {dx, {NDIV_Q_W{1'b0}}} + (NDIV_DEN_W+NDIV_Q_W)'(half_width_reg >> 1);
        num_y = {dy, {NDIV_Q_W{1'b0}}} + (NDIV_DEN_W+NDIV_Q_W)'(half_height_reg >> 1);
    end

    logic                nx_valid;
    logic [NDIV_Q_W-1:0] qx, qy;
    logic [CH_VEC_W:0]   nx_pay;
    logic [0:0]          ny_pay;

    stpb_div #(.DEN_W(NDIV_DEN_W), .Q_W(NDIV_Q_W), .PAY_W(CH_VEC_W + 1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .in_num(num_x), .in_den(half_width_reg),
        .in_pay({sat_x, ch_in}),
        .out_valid(nx_valid), .out_quo(qx), .out_pay(nx_pay)
    );

    stpb_div #(.DEN_W(NDIV_DEN_W), .Q_W(NDIV_Q_W), .PAY_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .in_num(num_y), .in_den(half_height_reg),
        .in_pay(sat_y),
        .out_valid(), .out_quo(qy), .out_pay(ny_pay)
    );

    // ---- weight products ----
    logic [W_BITS:0]     vx, vy, vdiff;
    logic                m1_valid_reg, m1_amb_reg;
    logic [2*W_BITS:0]   m1_p_reg, m1_q_reg;
    logic [CH_VEC_W-1:0] m1_ch_reg;

    always_comb
    begin
        vx    = nx_pay[CH_VEC_W] ? W_ONE : {1'b0, qx};
        vy    = ny_pay[0]        ? W_ONE : {1'b0, qy};
        vdiff = (vx >= vy) ? vx - vy : vy - vx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= nx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_amb_reg <= (vdiff >= AMBIG_LIMIT);
            m1_p_reg   <= (2*W_BITS+1)'(vx * vy);
            m1_q_reg   <= (2*W_BITS+1)'((W_ONE - vx) * (W_ONE - vy));
            m1_ch_reg  <= nx_pay[CH_VEC_W-1:0];
        end
    end

    // ---- weight division ----
    logic [WDIV_DEN_W-1:0]          wsum;
    logic [WDIV_DEN_W+WDIV_Q_W-1:0] num_w;

    always_comb
    begin
        wsum  = WDIV_DEN_W'(m1_p_reg) + WDIV_DEN_W'(m1_q_reg);
        num_w = {(WDIV_DEN_W - 1)'(m1_p_reg), {W_BITS{1'b0}}}
              + (WDIV_DEN_W+WDIV_Q_W)'(wsum >> 1);
    end

    logic                wd_valid;
    logic [WDIV_Q_W-1:0] wq;
    logic [CH_VEC_W:0]   wd_pay;

    stpb_div #(.DEN_W(WDIV_DEN_W), .Q_W(WDIV_Q_W), .PAY_W(CH_VEC_W + 1)) u_div_w (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(m1_valid_reg), .in_num(num_w), .in_den(wsum),
        .in_pay({m1_amb_reg, m1_ch_reg}),
        .out_valid(wd_valid), .out_quo(wq), .out_pay(wd_pay)
    );

    // ---- alpha weights ----
    logic [W_BITS:0]     w;
    logic                m3_valid_reg;
    logic [2*W_BITS-1:0] m3_a_reg, m3_b_reg;
    logic [CH_VEC_W-1:0] m3_ch_reg;

    assign w = wd_pay[CH_VEC_W] ? '0 : wq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m3_valid_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_a_reg  <= (2*W_BITS)'(wd_pay[3*CH_BITS +: CH_BITS] * (W_ONE - w));
            m3_b_reg  <= (2*W_BITS)'(wd_pay[7*CH_BITS +: CH_BITS] * w);
            m3_ch_reg <= wd_pay[CH_VEC_W-1:0];
        end
    end

    // ---- alpha and premultiplied colour products ----
    logic [2*W_BITS-1:0]          asum;
    logic [2*W_BITS:0]            alpha_round;
    logic                         m4_valid_reg;
    logic [2*W_BITS-1:0]          m4_sum_reg;
    logic [CH_BITS-1:0]           m4_alpha_reg;
    logic [CH_BITS+2*W_BITS-1:0]  m4_po_reg [0:2];
    logic [CH_BITS+2*W_BITS-1:0]  m4_pr_reg [0:2];

    assign asum        = m3_a_reg + m3_b_reg;
    assign alpha_round = {1'b0, asum} + (2*W_BITS+1)'(W_ONE >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m4_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_sum_reg   <= asum;
            m4_alpha_reg <= alpha_round[W_BITS +: CH_BITS];
            for (int i = 0; i < 3; i++)
            begin
                m4_po_reg[i] <= m3_ch_reg[i*CH_BITS +: CH_BITS] * m3_a_reg;
                m4_pr_reg[i] <= m3_ch_reg[(i+4)*CH_BITS +: CH_BITS] * m3_b_reg;
            end
        end
    end

    // ---- colour division, one lane per channel ----
    logic                cd_valid;
    logic [CH_BITS-1:0]  cd_alpha;
    logic [CDIV_Q_W-1:0] cq [0:2];

    for (genvar c = 0; c < 3; c++)
    begin : g_col
        logic [CDIV_DEN_W+CDIV_Q_W-1:0] num_c;

        assign num_c = m4_po_reg[c] + m4_pr_reg[c]
                     + (CDIV_DEN_W+CDIV_Q_W)'(m4_sum_reg >> 1);

        if (c == 0)
        begin : g_lead
            stpb_div #(.DEN_W(CDIV_DEN_W), .Q_W(CDIV_Q_W), .PAY_W(CH_BITS)) u_div_c (
                .clk(clk), .rst_n(rst_n), .en(en),
                .in_valid(m4_valid_reg), .in_num(num_c), .in_den(m4_sum_reg),
                .in_pay(m4_alpha_reg),
                .out_valid(cd_valid), .out_quo(cq[c]), .out_pay(cd_alpha)
            );
        end
        else
        begin : g_lane
            stpb_div #(.DEN_W(CDIV_DEN_W), .Q_W(CDIV_Q_W), .PAY_W(1)) u_div_c (
                .clk(clk), .rst_n(rst_n), .en(en),
                .in_valid(m4_valid_reg), .in_num(num_c), .in_den(m4_sum_reg),
                .in_pay(1'b0),
                .out_valid(), .out_quo(cq[c]), .out_pay()
            );
        end
    end

    // ---- output register ----
    logic alpha_zero;
    assign alpha_zero = (cd_alpha == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {cd_alpha,
                             alpha_zero ? {CH_BITS{1'b0}} : cq[2],
                             alpha_zero ? {CH_BITS{1'b0}} : cq[1],
                             alpha_zero ? {CH_BITS{1'b0}} : cq[0]};
        end
    end

endmodule

/* hdl/stpb_checker.sv */
// Port-level checks for seamless_tile_pixel_blend, bound to the top level.
// Depends on stpb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stpb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [stpb_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // a held result item stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // a blocked output stalls the input side
    `ASSERT_IMPLY(a_stall_prop, clk, rst_n, m_tvalid && !m_tready, !s_tready)

    // zero alpha forces zero colour
    `ASSERT_IMPLY(a_zero_alpha, clk, rst_n, m_tvalid && (m_tdata[63:48] == 16'd0),
                  m_tdata[47:0] == 48'd0)

    // configuration writes are never refused
    `ASSERT_IMPLY(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind seamless_tile_pixel_blend stpb_checker u_stpb_checker (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
